[rtl/c3f_pkg.sv]
// ----------------------------------------------------------------------------
// c3f_pkg: shared definitions for the 3x3 clamped image filter
// Default sizes, configuration register codes and register reset values.
// ----------------------------------------------------------------------------
package c3f_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_PIXEL_BITS = 8;
  localparam int unsigned DEF_COEF_BITS  = 8;

  // Fixed register widths.
  localparam int unsigned KROW_BITS     = 24;
  localparam int unsigned CLAMP_BITS    = 8;
  localparam int unsigned WIDTH_BITS    = 11;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 24;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MIDDLE = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_CLAMP_LOW     = 3'd3,
    REG_CLAMP_HIGH    = 3'd4,
    REG_IMAGE_WIDTH   = 3'd5
  } cfg_reg_e;

  // Register reset values.
  localparam logic [KROW_BITS-1:0]         KERNEL_TOP_RESET    = 24'd0;
  localparam logic [KROW_BITS-1:0]         KERNEL_MIDDLE_RESET = 24'd256;
  localparam logic [KROW_BITS-1:0]         KERNEL_BOTTOM_RESET = 24'd0;
  localparam logic signed [CLAMP_BITS-1:0] CLAMP_LOW_RESET     = -8'sd20;
  localparam logic signed [CLAMP_BITS-1:0] CLAMP_HIGH_RESET    = 8'sd20;
  localparam logic [WIDTH_BITS-1:0]        IMAGE_WIDTH_RESET   = 11'd1024;

endpackage

[rtl/c3f_stream_if.sv]
// ----------------------------------------------------------------------------
// c3f_stream_if: pixel and result channels of the 3x3 clamped image filter
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface c3f_pix_if
  import c3f_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;
  logic                         flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface c3f_res_if
  import c3f_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] filtered;
  logic                         last_in_run;
  logic                         end_of_image;

  modport source (output valid, output filtered, output last_in_run,
                  output end_of_image, input ready);
  modport sink   (input valid, input filtered, input last_in_run,
                  input end_of_image, output ready);
endinterface

[rtl/conv3x3_clamped_image_filter.sv]
// ----------------------------------------------------------------------------
// conv3x3_clamped_image_filter: 3x3 correlation with line buffers and clamp
// Streams signed pixels in raster order and emits clamped filtered pixels.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on pix_i in raster order, one word per accepted handshake.
// After the last image row the source sends image_width words with flush set;
// they form the zero bottom padding row, and the flush word at the last column
// ends the image. Results leave on res_o. Output lags the input by one row and
// one column: the first row gives no results, column 0 gives none, columns 1
// to W-2 give one each and the last column gives two (last_in_run marks the
// final one of a word, end_of_image the final pixel of the image).
// An accepted word is registered in the compute stage and its results in the
// result buffer that drives res_o. Throughput is one word per clock while
// res_o does not stall; the two results of a row end overlap the column-0
// word that follows. The rate is set by the single compute stage that reads
// both line buffers (one read and one write port each) and forms 18 products.
// When res_o stalls, the compute stage holds as soon as a result is waiting
// and its own word has results, and pix_i.ready drops. Words without results
// still pass, so the two-entry result buffer only fills at a row end. Reset
// empties the pipeline, clears column and row counters and the window, and
// loads the register defaults; line buffer contents are left as they are.
// Configure only while the block is idle.
// ----------------------------------------------------------------------------
module conv3x3_clamped_image_filter
  import c3f_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int unsigned COEF_BITS  = DEF_COEF_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  c3f_pix_if.sink                  pix_i,
  c3f_res_if.source                res_o
);

  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned WCMP      = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;
  localparam int unsigned EXT_BITS  = KROW_BITS + 3 * COEF_BITS;
  localparam int unsigned PROD_BITS = PIXEL_BITS + COEF_BITS;
  localparam int unsigned SUM_BITS  = PROD_BITS + 4;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [KROW_BITS-1:0]         kern_q [3];
  logic signed [CLAMP_BITS-1:0] clamp_low_q;
  logic signed [CLAMP_BITS-1:0] clamp_high_q;
  logic [WIDTH_BITS-1:0]        width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q[0]    <= KERNEL_TOP_RESET;
      kern_q[1]    <= KERNEL_MIDDLE_RESET;
      kern_q[2]    <= KERNEL_BOTTOM_RESET;
      clamp_low_q  <= CLAMP_LOW_RESET;
      clamp_high_q <= CLAMP_HIGH_RESET;
      width_q      <= IMAGE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KERNEL_TOP:    kern_q[0]    <= cfg_data_i[KROW_BITS-1:0];
        REG_KERNEL_MIDDLE: kern_q[1]    <= cfg_data_i[KROW_BITS-1:0];
        REG_KERNEL_BOTTOM: kern_q[2]    <= cfg_data_i[KROW_BITS-1:0];
        REG_CLAMP_LOW:     clamp_low_q  <= cfg_data_i[CLAMP_BITS-1:0];
        REG_CLAMP_HIGH:    clamp_high_q <= cfg_data_i[CLAMP_BITS-1:0];
        REG_IMAGE_WIDTH:   width_q      <= cfg_data_i[WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Coefficients: row r, tap t, left tap in the low bits. Taps that fall past
  // the register read as zero.
  logic [EXT_BITS-1:0]         krow_ext [3];
  logic signed [COEF_BITS-1:0] coef [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    assign krow_ext[r] = EXT_BITS'(kern_q[r]);
    for (genvar t = 0; t < 3; t++) begin : g_tap
      assign coef[r][t] = krow_ext[r][t*COEF_BITS +: COEF_BITS];
    end
  end

  // Width in use: zero counts as one, anything above the buffer depth is cut.
  logic [WCMP-1:0] w_raw;
  logic [WCMP-1:0] w_eff;

  always_comb begin
    w_raw = WCMP'(width_q);
    if (w_raw == '0) begin
      w_eff = WCMP'(1);
    end else if (w_raw > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and position tracking at the input.
  // --------------------------------------------------------------------------
  logic          in_fire;
  logic          s1_adv;
  logic          s1_v_q;
  logic [CW-1:0] col_q;
  logic [CW-1:0] col_d;
  logic [1:0]    rows_q;
  logic [1:0]    rows_d;
  logic          in_last;

  assign pix_i.ready = !s1_v_q || s1_adv;
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign in_last     = (WCMP'(col_q) >= w_eff - WCMP'(1));

  always_comb begin
    col_d  = col_q;
    rows_d = rows_q;
    if (in_fire) begin
      if (in_last) begin
        col_d = '0;
        if (pix_i.flush) begin
          rows_d = 2'd0;
        end else if (rows_q != 2'd2) begin
          rows_d = rows_q + 2'd1;
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Compute stage registers. The line buffers are read at the accept edge,
  // so their data lines up with this stage.
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] s1_bot_q;
  logic                         s1_flush_q;
  logic [CW-1:0]                s1_col_q;
  logic                         s1_last_q;
  logic                         s1_first_q;
  logic [1:0]                   s1_rows_q;
  logic                         fwd_q;
  logic                         fwd_hit;

  // The next word reads the address this stage writes at the same edge only
  // when the width is one; its read data is then taken from this stage.
  assign fwd_hit = in_fire && s1_adv && (col_q == s1_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
      col_q  <= '0;
      rows_q <= 2'd0;
    end else begin
      col_q  <= col_d;
      rows_q <= rows_d;
      if (in_fire) begin
        s1_v_q <= 1'b1;
        fwd_q  <= fwd_hit;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bot_q   <= pix_i.flush ? '0 : pix_i.pixel;
      s1_flush_q <= pix_i.flush;
      s1_col_q   <= col_q;
      s1_last_q  <= in_last;
      s1_first_q <= (col_q == '0);
      s1_rows_q  <= rows_q;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffers: the row above and the row above that.
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] lp_mem  [MAX_WIDTH];
  logic signed [PIXEL_BITS-1:0] lbp_mem [MAX_WIDTH];
  logic signed [PIXEL_BITS-1:0] lp_rd_q;
  logic signed [PIXEL_BITS-1:0] lbp_rd_q;
  logic signed [PIXEL_BITS-1:0] fwd_lp_q;
  logic signed [PIXEL_BITS-1:0] fwd_lbp_q;
  logic signed [PIXEL_BITS-1:0] lp_eff;
  logic signed [PIXEL_BITS-1:0] lbp_eff;

  assign lp_eff  = fwd_q ? fwd_lp_q  : lp_rd_q;
  assign lbp_eff = fwd_q ? fwd_lbp_q : lbp_rd_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lp_mem[s1_col_q] <= s1_bot_q;
    end
    if (in_fire) begin
      lp_rd_q <= lp_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lbp_mem[s1_col_q] <= lp_eff;
    end
    if (in_fire) begin
      lbp_rd_q <= lbp_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_lp_q  <= s1_bot_q;
      fwd_lbp_q <= lp_eff;
    end
  end

  // --------------------------------------------------------------------------
  // Window: the two most recent columns are kept; the new column comes from
  // the line buffers and the current word. Rows not yet seen read as zero.
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] win_q    [3][2];
  logic signed [PIXEL_BITS-1:0] new_col  [3];
  logic signed [PIXEL_BITS-1:0] win_cur  [3][3];
  logic signed [PIXEL_BITS-1:0] win_edge [3][3];

  assign new_col[0] = (s1_rows_q == 2'd2) ? lbp_eff : '0;
  assign new_col[1] = (s1_rows_q != 2'd0) ? lp_eff  : '0;
  assign new_col[2] = s1_bot_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_cur[i][0]  = s1_first_q ? '0 : win_q[i][0];
      win_cur[i][1]  = s1_first_q ? '0 : win_q[i][1];
      win_cur[i][2]  = new_col[i];
      // Right border: shift once more and pad with zero.
      win_edge[i][0] = win_cur[i][1];
      win_edge[i][1] = win_cur[i][2];
      win_edge[i][2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_cur[i][1];
        win_q[i][1] <= win_cur[i][2];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Weighted sum and clamp. The upper bound is tested first.
  // --------------------------------------------------------------------------
  function automatic logic signed [PIXEL_BITS-1:0] filter3x3(
    input logic signed [PIXEL_BITS-1:0] win [3][3]
  );
    logic signed [SUM_BITS-1:0]  acc;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [SUM_BITS-1:0]  lo;
    logic signed [SUM_BITS-1:0]  hi;
    acc = '0;
    lo  = SUM_BITS'(clamp_low_q);
    hi  = SUM_BITS'(clamp_high_q);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod = coef[i][j] * win[i][j];
        acc  = acc + SUM_BITS'(prod);
      end
    end
    if (acc > hi) begin
      acc = hi;
    end else if (acc < lo) begin
      acc = lo;
    end
    return acc[PIXEL_BITS-1:0];
  endfunction

  logic                         has_main;
  logic                         has_edge;
  logic [1:0]                   n_res;
  logic signed [PIXEL_BITS-1:0] main_val;
  logic signed [PIXEL_BITS-1:0] edge_val;

  assign has_main = (s1_rows_q != 2'd0) && !s1_first_q;
  assign has_edge = (s1_rows_q != 2'd0) && s1_last_q;
  assign n_res    = {1'b0, has_main} + {1'b0, has_edge};

  // The sums also depend on the coefficient and clamp registers, so they are
  // evaluated in a block that follows every signal the function reads.
  always_comb begin
    main_val = filter3x3(win_cur);
    edge_val = filter3x3(win_edge);
  end

  // --------------------------------------------------------------------------
  // Two-entry result buffer; entry 0 drives the output.
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] ob_val_q [2];
  logic                         ob_lir_q [2];
  logic                         ob_eoi_q [2];
  logic [1:0]                   ob_cnt_q;
  logic [1:0]                   ob_cnt_d;
  logic                         out_fire;
  logic                         ob_free;

  assign res_o.valid        = (ob_cnt_q != 2'd0);
  assign res_o.filtered     = ob_val_q[0];
  assign res_o.last_in_run  = ob_lir_q[0];
  assign res_o.end_of_image = ob_eoi_q[0];

  assign out_fire = res_o.valid && res_o.ready;
  assign ob_free  = (ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && out_fire);
  assign s1_adv   = s1_v_q && ((n_res == 2'd0) || ob_free);

  always_comb begin
    ob_cnt_d = ob_cnt_q - {1'b0, out_fire};
    if (s1_adv) begin
      ob_cnt_d = ob_cnt_d + n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else begin
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (n_res != 2'd0)) begin
      ob_val_q[0] <= has_main ? main_val : edge_val;
      ob_lir_q[0] <= has_main ? !s1_last_q : 1'b1;
      ob_eoi_q[0] <= has_main ? 1'b0 : s1_flush_q;
      ob_val_q[1] <= edge_val;
      ob_lir_q[1] <= 1'b1;
      ob_eoi_q[1] <= s1_flush_q;
    end else if (out_fire) begin
      ob_val_q[0] <= ob_val_q[1];
      ob_lir_q[0] <= ob_lir_q[1];
      ob_eoi_q[0] <= ob_eoi_q[1];
    end
  end

endmodule

[rtl/c3f_checker.sv]
// ----------------------------------------------------------------------------
// c3f_checker: port-level checks for the 3x3 clamped image filter
// Watches the pixel and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module c3f_checker
  import c3f_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [PIXEL_BITS-1:0] filtered_i,
  input logic                         last_in_run_i,
  input logic                         end_of_image_i
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(filtered_i) && $stable(last_in_run_i) && $stable(end_of_image_i))
    else $error("result payload changed while stalled");

  // The final pixel of an image is always the last result of its word.
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && end_of_image_i |-> last_in_run_i)
    else $error("end of image without last in run");

  // The input only stalls while results are waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // Input ready is a known value in the cycle after a word is taken.
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$isunknown(in_ready_i))
    else $error("input ready unknown after a transfer");

endmodule

bind conv3x3_clamped_image_filter c3f_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_c3f_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (pix_i.valid),
  .in_ready_i     (pix_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .filtered_i     (res_o.filtered),
  .last_in_run_i  (res_o.last_in_run),
  .end_of_image_i (res_o.end_of_image)
);

[bench/c3f_tb_pkg.sv]
// ----------------------------------------------------------------------------
// c3f_tb_pkg: result tracking for the 3x3 clamped image filter bench
// Holds a software copy of the filter that predicts every output pixel word
// from the accepted input words, and compares the block's results with it.
// ----------------------------------------------------------------------------
package c3f_tb_pkg;
  import c3f_pkg::*;

  typedef logic signed [DEF_PIXEL_BITS-1:0] pixel_t;
  typedef pixel_t patch_t [3][3];

  typedef struct packed {
    pixel_t filtered;
    logic   last_in_run;
    logic   end_of_image;
  } out_word_t;

  class c3f_filter_check;
    logic [KROW_BITS-1:0]  kernel_rows [3];
    pixel_t                clamp_lo;
    pixel_t                clamp_hi;
    logic [WIDTH_BITS-1:0] width_reg;
    pixel_t                line_above [DEF_MAX_WIDTH];
    pixel_t                line_two_above [DEF_MAX_WIDTH];
    patch_t                window;
    int unsigned           column;
    int unsigned           rows_done;
    out_word_t             expected_pixels [$];
    int unsigned           mismatch_count;
    int unsigned           results_seen;

    function new();
      kernel_rows[0] = KERNEL_TOP_RESET;
      kernel_rows[1] = KERNEL_MIDDLE_RESET;
      kernel_rows[2] = KERNEL_BOTTOM_RESET;
      clamp_lo       = CLAMP_LOW_RESET;
      clamp_hi       = CLAMP_HIGH_RESET;
      width_reg      = IMAGE_WIDTH_RESET;
      foreach (line_above[i]) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      foreach (window[i, j]) window[i][j] = '0;
      column         = 0;
      rows_done      = 0;
      mismatch_count = 0;
      results_seen   = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_KERNEL_TOP:    kernel_rows[0] = data[KROW_BITS-1:0];
        REG_KERNEL_MIDDLE: kernel_rows[1] = data[KROW_BITS-1:0];
        REG_KERNEL_BOTTOM: kernel_rows[2] = data[KROW_BITS-1:0];
        REG_CLAMP_LOW:     clamp_lo       = data[CLAMP_BITS-1:0];
        REG_CLAMP_HIGH:    clamp_hi       = data[CLAMP_BITS-1:0];
        REG_IMAGE_WIDTH:   width_reg      = data[WIDTH_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Width register as the block uses it: zero acts as one column and
    // anything past the line buffer depth as the full depth.
    function int unsigned used_width();
      if (width_reg == 0) return 1;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    // Correlation without kernel flip, then the clamp with the upper bound
    // tested first.
    function pixel_t apply_kernel(patch_t px);
      int acc;
      int i;
      int j;
      acc = 0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          acc += int'($signed(kernel_rows[i][DEF_COEF_BITS*j +: DEF_COEF_BITS])) *
                 int'(px[i][j]);
        end
      end
      if (acc > int'(clamp_hi)) return clamp_hi;
      if (acc < int'(clamp_lo)) return clamp_lo;
      return pixel_t'(acc);
    endfunction

    function void predict_word(pixel_t pixel, logic flush);
      int unsigned w;
      int unsigned c;
      bit          is_last;
      pixel_t      bottom;
      pixel_t      top;
      pixel_t      mid;
      patch_t      edge_patch;
      out_word_t   word;
      int          i;
      w = used_width();
      c = column;
      if (c >= DEF_MAX_WIDTH) c = DEF_MAX_WIDTH - 1;
      is_last = (c >= w - 1);
      bottom  = flush ? pixel_t'(0) : pixel;
      top     = (rows_done >= 2) ? line_two_above[c] : pixel_t'(0);
      mid     = (rows_done >= 1) ? line_above[c] : pixel_t'(0);
      line_two_above[c] = line_above[c];
      line_above[c]     = bottom;

      for (i = 0; i < 3; i++) begin
        window[i][0] = (c == 0) ? pixel_t'(0) : window[i][1];
        window[i][1] = (c == 0) ? pixel_t'(0) : window[i][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = bottom;

      if (rows_done >= 1) begin
        if (c >= 1) begin
          word.filtered     = apply_kernel(window);
          word.last_in_run  = !is_last;
          word.end_of_image = 1'b0;
          expected_pixels.push_back(word);
        end
        if (is_last) begin
          // The last column also produces its own pixel, with zero padding
          // on the right.
          for (i = 0; i < 3; i++) begin
            edge_patch[i][0] = window[i][1];
            edge_patch[i][1] = window[i][2];
            edge_patch[i][2] = '0;
          end
          word.filtered     = apply_kernel(edge_patch);
          word.last_in_run  = 1'b1;
          word.end_of_image = flush;
          expected_pixels.push_back(word);
        end
      end

      if (is_last) begin
        column = 0;
        if (flush) rows_done = 0;
        else if (rows_done < 2) rows_done++;
      end else begin
        column = c + 1;
      end
    endfunction

    function void compare_result(pixel_t filtered, logic last_in_run, logic end_of_image);
      out_word_t want;
      results_seen++;
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: got %0d last_in_run %0b end_of_image %0b, none expected",
                   results_seen, filtered, last_in_run, end_of_image);
        return;
      end
      want = expected_pixels.pop_front();
      if (want.filtered !== filtered || want.last_in_run !== last_in_run ||
          want.end_of_image !== end_of_image) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: got %0d/%0b/%0b, expected %0d/%0b/%0b (filtered/last/end)",
                   results_seen, filtered, last_in_run, end_of_image,
                   want.filtered, want.last_in_run, want.end_of_image);
      end
    endfunction
  endclass

endpackage

[bench/tb_conv3x3_clamped_image_filter.sv]
// ----------------------------------------------------------------------------
// tb_conv3x3_clamped_image_filter: stream bench for the 3x3 clamped filter
// Drives pixel words with bursty timing, stalls the result side on changing
// patterns, predicts every output pixel in software and checks each result.
// ----------------------------------------------------------------------------
module tb_conv3x3_clamped_image_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import c3f_pkg::*;
  import c3f_tb_pkg::*;

  // Random part stops once this many words have gone in.
  localparam int unsigned RANDOM_WORDS  = 600;
  // Length of the one long result stall that backs the block up.
  localparam int unsigned LONG_HOLD     = 300;
  // Cycles let pass after the last expected result before the block is
  // treated as idle; covers words that are still in the pipe but give none.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_THROTTLE,
    RX_TRICKLE
  } rx_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  c3f_pix_if pix ();
  c3f_res_if res ();

  conv3x3_clamped_image_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  c3f_filter_check tracker = new();

  // Words left in the current sender burst; at zero a gap comes first.
  int unsigned burst_left    = 0;
  int unsigned random_words  = 0;
  // Set by the stimulus to ask the result side for one long stall.
  bit          long_hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Every accepted result word goes straight to the tracker. Ready is driven
  // at the falling edge, so both sides are stable here.
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready)
      tracker.compare_result(res.filtered, res.last_in_run, res.end_of_image);
  end

  // Result side: ready follows a mode that is picked anew at random, from
  // wide open to nearly shut. A long stall request drops ready while the
  // source keeps pushing.
  initial begin
    rx_mode_e    mode;
    int unsigned stretch;
    int unsigned beat;
    res.ready = 1'b0;
    mode      = RX_OPEN;
    stretch   = 0;
    beat      = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (stretch == 0) begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(8, 60);
        beat    = 0;
      end
      stretch--;
      beat++;
      case (mode)
        RX_OPEN:     res.ready <= 1'b1;
        RX_COIN:     res.ready <= 1'($urandom);
        RX_THROTTLE: res.ready <= (beat % 3) != 0;
        default:     res.ready <= (beat % 6) == 0;
      endcase
    end
  end

  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'sh80;
      1:       return 8'sh7F;
      2:       return '0;
      3:       return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // Offers one word and returns at the falling edge after it was taken.
  // Valid is left high so that back-to-back words flow without a bubble;
  // a gap is inserted only when the current burst is used up.
  task automatic drive_word(input pixel_t p, input logic f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    pix.flush <= f;
    do @(posedge clk_i); while (!pix.ready);
    tracker.predict_word(p, f);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every predicted result has been seen and
  // the pipe has had time to settle. Returns at a falling edge.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register write; the caller lowers the write enable after the last.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [KROW_BITS-1:0] k_top,
                               input logic [KROW_BITS-1:0] k_mid,
                               input logic [KROW_BITS-1:0] k_bot,
                               input logic [CFG_DATA_BITS-1:0] lo_word,
                               input logic [CFG_DATA_BITS-1:0] hi_word,
                               input logic [CFG_DATA_BITS-1:0] width_word);
    write_reg(REG_KERNEL_TOP, k_top);
    write_reg(REG_KERNEL_MIDDLE, k_mid);
    write_reg(REG_KERNEL_BOTTOM, k_bot);
    write_reg(REG_CLAMP_LOW, lo_word);
    write_reg(REG_CLAMP_HIGH, hi_word);
    write_reg(REG_IMAGE_WIDTH, width_word);
    cfg_we_i <= 1'b0;
  endtask

  // Random kernel, clamp and width. The width may only grow while no row
  // of the current image is complete; otherwise the filter would read line
  // buffer entries that were never filled.
  task automatic random_setting();
    logic [KROW_BITS-1:0]     k [3];
    pixel_t                   lo;
    pixel_t                   hi;
    pixel_t                   t;
    int unsigned              cap;
    int unsigned              wv;
    logic [31:0]              junk;
    logic [CFG_DATA_BITS-1:0] lo_w;
    logic [CFG_DATA_BITS-1:0] hi_w;
    logic [CFG_DATA_BITS-1:0] w_w;
    int                       i;
    int                       j;
    for (i = 0; i < 3; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        // Small taps keep most sums inside the clamp window.
        for (j = 0; j < 3; j++)
          k[i][DEF_COEF_BITS*j +: DEF_COEF_BITS] = 8'($urandom_range(0, 6) - 3);
      end else begin
        k[i] = KROW_BITS'($urandom);
      end
    end
    lo = pixel_t'($urandom);
    hi = pixel_t'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        lo = 8'sh80;
        hi = 8'sh7F;
      end
      1, 2: ;
      default: begin
        if (lo > hi) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
      end
    endcase
    cap = (tracker.rows_done == 0) ? 40 : tracker.used_width();
    case ($urandom_range(0, 9))
      0:       wv = 0;
      1:       wv = $urandom_range(1, cap);
      default: wv = $urandom_range(1, (cap < 10) ? cap : 10);
    endcase
    // Bits above each field are sometimes set; the block must ignore them.
    junk = $urandom;
    lo_w = {junk[15:0], lo};
    hi_w = {junk[31:16], hi};
    w_w  = {junk[12:0], WIDTH_BITS'(wv)};
    if ($urandom_range(0, 2) != 0) begin
      lo_w[CFG_DATA_BITS-1:CLAMP_BITS] = '0;
      hi_w[CFG_DATA_BITS-1:CLAMP_BITS] = '0;
      w_w[CFG_DATA_BITS-1:WIDTH_BITS]  = '0;
    end
    apply_setting(k[0], k[1], k[2], lo_w, hi_w, w_w);
  endtask

  // A few image rows and then the flush row. Now and then a stray flush
  // word lands inside the image, and some images are cut short so that the
  // next setting starts in the middle of a row.
  task automatic send_image();
    int unsigned w;
    int unsigned rows;
    int unsigned total;
    int unsigned k;
    logic        f;
    w     = tracker.used_width();
    rows  = $urandom_range(1, 4);
    total = (rows + 1) * w;
    if ($urandom_range(0, 5) == 0) total = $urandom_range(1, total);
    for (k = 0; k < total; k++) begin
      f = (k >= rows * w) || ($urandom_range(0, 24) == 0);
      drive_word(random_pixel(), f);
      random_words++;
    end
  endtask

  initial begin
    int unsigned i;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_KERNEL_TOP;
    cfg_data_i = '0;
    pix.valid  = 1'b0;
    pix.pixel  = '0;
    pix.flush  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset kernel and clamp on a short image: only the width register is
    // written, so the default taps and bounds decide every result.
    write_reg(REG_IMAGE_WIDTH, 24'd6);
    cfg_we_i <= 1'b0;
    for (i = 0; i < 18; i++)
      drive_word(random_pixel(), 1'b0);
    repeat (6) drive_word(random_pixel(), 1'b1);
    wait_idle();

    // Width beyond the line buffer depth must act as the full depth; a new
    // image starts and its first row runs on into the next setting.
    apply_setting(24'h03FF01, 24'hFE05FE, 24'h01FF03, 24'h0000C0, 24'h000040, 24'h0007FF);
    repeat (4) drive_word(random_pixel(), 1'b0);
    wait_idle();

    // Extreme taps with the widest clamp window. The width drops to three
    // while the current column is past it, so the next word closes the
    // row as if it were the last column.
    apply_setting(24'h807F01, 24'h7F807F, 24'hFF0180, 24'h000080, 24'h00007F, 24'h000003);
    drive_word(8'sh7F, 1'b0);
    drive_word(8'sh80, 1'b0);
    drive_word(8'sh7F, 1'b0);
    drive_word(8'sh00, 1'b0);
    drive_word(8'sh7F, 1'b0);
    drive_word(8'sh80, 1'b0);
    drive_word(-8'sd1, 1'b0);
    repeat (3) drive_word(8'sh55, 1'b1);
    wait_idle();

    // Zero width acts as one column, and the clamp bounds are crossed so
    // that the upper test decides. The leading flush word closes an image
    // that has not started.
    apply_setting(24'h00FE00, 24'h7F057F, 24'h00FD00, 24'h00001E, 24'h0000E2, 24'h000000);
    drive_word(8'sh2A, 1'b1);
    drive_word(8'sd5, 1'b0);
    drive_word(-8'sd7, 1'b0);
    drive_word(8'sh7F, 1'b0);
    drive_word(8'sh80, 1'b1);
    wait_idle();

    // Two columns with a flush word at column zero inside the image: it is
    // only a zero pixel and must not end anything.
    apply_setting(24'h010101, 24'h010101, 24'h010101, 24'h00009C, 24'h000064, 24'h000002);
    drive_word(8'sh7F, 1'b1);
    drive_word(8'sd9, 1'b0);
    drive_word(8'sd100, 1'b0);
    drive_word(-8'sd100, 1'b0);
    repeat (2) drive_word(8'sh00, 1'b1);
    wait_idle();

    // Random settings and images. The long result stall comes right at the
    // start of the first random image so the block fills and pushes back.
    while (random_words < RANDOM_WORDS) begin
      random_setting();
      if (random_words == 0) long_hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) send_image();
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/c3f_pkg.sv
rtl/c3f_stream_if.sv
rtl/conv3x3_clamped_image_filter.sv
rtl/c3f_checker.sv
bench/c3f_tb_pkg.sv
bench/tb_conv3x3_clamped_image_filter.sv
